// ===== sv/arfh_pkg.sv =====
// Package: constants, tables and helper functions for the AES round fold hash.
package arfh_pkg;

    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_A  = 64'h0000_0000_85eb_ca6b;
    localparam logic [63:0] MIX_B  = 64'h0000_0000_c2b2_ae35;
    localparam logic [5:0]  FULL_COUNT = 6'd32;

    // round key, bytes 0..31 as little-endian words
    localparam logic [255:0] ROUND_KEY = {
        64'hf95524bf9f2fdfa8, 64'hf3fb6d8bd7643b1d,
        64'ha70413383f55618f, 64'h376d0932e21de58f};

    typedef logic [127:0] half_t;

    localparam logic [7:0] SBOX [256] = '{
     8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
     8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
     8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
     8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
     8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
     8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
     8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
     8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
     8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
     8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
     8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
     8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
     8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
     8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
     8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
     8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // control passed from the input stage to the finish stage
    typedef struct packed {
        logic        start;
        logic        full;
        logic        last;
        logic [63:0] tail;
    } blk_ctl_t;

endpackage

// ===== sv/arfh_lane.sv =====
// One AES encryption round on a 128-bit half block, registered output.
module arfh_lane (
    input  logic           aclk,
    input  logic           en,
    input  arfh_pkg::half_t state_in,
    input  arfh_pkg::half_t round_key,
    output arfh_pkg::half_t state_out
);
    import arfh_pkg::*;

    logic [7:0] sub_b [16];
    half_t      mixed;
    half_t      out_reg;

    // SubBytes with ShiftRows folded into the byte pick
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sub_b[r + 4 * c] = SBOX[state_in[8 * (r + 4 * ((c + r) % 4)) +: 8]];
            end
        end
    end

    // MixColumns and key add
    always_comb begin
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0 = sub_b[4 * c];
            a1 = sub_b[4 * c + 1];
            a2 = sub_b[4 * c + 2];
            a3 = sub_b[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            mixed[32 * c +: 8]      = a0 ^ all ^ xtime(a0 ^ a1) ^ round_key[32 * c +: 8];
            mixed[32 * c + 8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2) ^ round_key[32 * c + 8 +: 8];
            mixed[32 * c + 16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3) ^ round_key[32 * c + 16 +: 8];
            mixed[32 * c + 24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0) ^ round_key[32 * c + 24 +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= mixed;
        end
    end

    assign state_out = out_reg;
endmodule

// ===== sv/arfh_tail.sv =====
// Tail word of a short final block: its first byte_count bytes, byte-reversed and XOR-folded into 64 bits.
module arfh_tail (
    input  logic [255:0] blk,
    input  logic [5:0]   byte_count,
    output logic [63:0]  tail
);
    import arfh_pkg::*;

    // byte j lands at lane (n-1-j) mod 8 when j < n
    always_comb begin
        logic [2:0] pos;
        tail = '0;
        for (int j = 0; j < 32; j++) begin
            pos = 3'(byte_count - 6'(j) - 6'd1);
            if (6'(j) < byte_count) begin
                tail = tail ^ ({56'd0, blk[8 * j +: 8]} << {pos, 3'b000});
            end
        end
    end
endmodule

// ===== sv/arfh_finish.sv =====
// Merge stage: folds lanes or tail into the accumulator, runs the final mix.
module arfh_finish (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  arfh_pkg::blk_ctl_t ctl,
    input  logic [255:0]      lanes,
    input  logic [63:0]       hash_seed,
    output logic              busy,
    output logic              done,
    output logic [63:0]       hash_value,
    input  logic              taken
);
    import arfh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_FOLD, S_A_LO, S_A_HI, S_B_LO, S_B_HI, S_X33, S_OUT
    } fin_state_t;

    fin_state_t  state_reg;
    blk_ctl_t    ctl_reg;
    logic        start_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [63:0] hash_reg;
    logic        valid_reg;
    logic        handoff;
    logic [63:0] fold;
    logic [63:0] h_fold;
    logic [63:0] x1;
    logic [31:0] mul_k;
    logic [31:0] mul_lo_in;
    logic [31:0] hi_prod;
    logic [63:0] lo_prod;

    assign fold = lanes[63:0] ^ lanes[127:64] ^ lanes[191:128] ^ lanes[255:192];
    assign h_fold = (ctl_reg.start ? (hash_seed ^ GOLDEN) : acc_reg)
                    ^ (ctl_reg.full ? fold : ctl_reg.tail);
    assign x1 = acc_reg ^ (acc_reg >> 29);

    // 64x32 multiply split into two 32x32 halves (low half, then high half)
    assign mul_k = ((state_reg == S_A_LO) || (state_reg == S_A_HI)) ? MIX_A[31:0]
                                                                    : MIX_B[31:0];
    assign mul_lo_in = (state_reg == S_B_LO) ? x1[31:0] : acc_reg[31:0];
    assign lo_prod = {32'd0, mul_lo_in} * {32'd0, mul_k};
    assign hi_prod = acc_reg[63:32] * mul_k;

    // hash moves to the output register once it is free
    assign handoff = (state_reg == S_OUT) && (!valid_reg || taken);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            start_reg <= 1'b1;
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (handoff) begin
                hash_reg  <= acc_reg;
                valid_reg <= 1'b1;
            end else if (taken) begin
                valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (load) begin
                        ctl_reg   <= '{start: start_reg, full: ctl.full, last: ctl.last,
                                       tail: ctl.tail};
                        start_reg <= ctl.last;
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    acc_reg <= h_fold;
                    if (ctl_reg.last) begin
                        state_reg <= S_A_LO;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_A_LO: begin
                    prod_reg  <= lo_prod;
                    state_reg <= S_A_HI;
                end
                S_A_HI: begin
                    acc_reg   <= prod_reg + {hi_prod, 32'd0};
                    state_reg <= S_B_LO;
                end
                S_B_LO: begin
                    acc_reg   <= x1;
                    prod_reg  <= lo_prod;
                    state_reg <= S_B_HI;
                end
                S_B_HI: begin
                    acc_reg   <= prod_reg + {hi_prod, 32'd0};
                    state_reg <= S_X33;
                end
                S_X33: begin
                    acc_reg   <= acc_reg ^ (acc_reg >> 33);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (handoff) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = valid_reg;
    assign hash_value = hash_reg;

    // a result shows only after a last block
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done) |-> ctl_reg.last) else $error("result without last block");
    a_out_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> start_reg) else $error("no message restart");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && !taken) |=> (done && $stable(hash_value))) else $error("result lost");
endmodule

// ===== sv/aes_round_fold_hash64.sv =====
// Top level: streaming AES round fold hash over 32-byte blocks.
//
// channel   dir  handshake             contents
// s_axis    in   s_tvalid/s_tready     one 32-byte block request
// cfg       in   cfg_valid/cfg_ready   hash seed
// m_axis    out  m_tvalid/m_tready     64-bit hash of a message
//
// A full block passes the lane round, then the fold. A last block goes
// through the fold, each 64x32 multiply done as 32x32 halves (low, then
// high), the final xorshift, then the move into the output register. The
// input is not ready while a block is in work, and stalls longer only while
// an older hash still waits for m_tready. Short non-last blocks are dropped at accept.
// Reset is synchronous on aresetn; the seed resets to zero.
module aes_round_fold_hash64 (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // word0, word1, word2, word3
    input  logic [5:0]   s_tuser,   // byte_count
    input  logic         s_tlast,   // last_block
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // hash_value
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_data
);
    import arfh_pkg::*;

    logic [63:0]  seed_reg;
    logic         busy;
    logic         accept;
    logic         full;
    logic         load;
    logic [63:0]  tail;
    logic [255:0] lanes;
    blk_ctl_t     ctl;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_valid) begin
            seed_reg <= cfg_data;
        end
    end

    assign s_tready = !busy;
    assign accept = s_tvalid && s_tready;
    assign full = (s_tuser >= FULL_COUNT);
    assign load = accept && (full || s_tlast);

    arfh_tail u_tail (.blk(s_tdata), .byte_count(s_tuser), .tail(tail));

    assign ctl = '{start: 1'b0, full: full, last: s_tlast, tail: full ? 64'd0 : tail};

    // two lanes, one per 128-bit half
    for (genvar g = 0; g < 2; g++) begin : g_lane
        arfh_lane u_lane (
            .aclk(aclk), .en(load),
            .state_in(s_tdata[128 * g +: 128]),
            .round_key(ROUND_KEY[128 * g +: 128]),
            .state_out(lanes[128 * g +: 128])
        );
    end

    arfh_finish u_finish (
        .aclk(aclk), .aresetn(aresetn), .load(load), .ctl(ctl), .lanes(lanes),
        .hash_seed(seed_reg), .busy(busy), .done(m_tvalid), .hash_value(m_tdata),
        .taken(m_tready)
    );
endmodule
